/* rtl/atu_pkg.sv */
// Shared types, constants and the Q1.30 multiply for the arctangent unit.
package atu_pkg;

  typedef enum logic [1:0] {
    CMD_ATAN  = 2'd0,
    CMD_ATAN2 = 2'd1,
    CMD_ACOS  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Flags that ride with a word from the quotient stage to the output.
  typedef struct packed {
    cmd_t cmd;
    logic xzero;
    logic xneg;
    logic yneg;
    logic ypos;
  } tag_t;

  localparam int SQRT_STEPS = 17;
  localparam int QUOT_STEPS = 31;
  localparam int RED_STEPS  = 30;

  localparam logic [31:0] ONE_Q16   = 32'd65536;
  localparam logic [31:0] TAN_3PI_8 = 32'd158218;
  localparam logic [31:0] TAN_PI_8  = 32'd27146;

  localparam logic signed [31:0] PI_HALF_Q30 = 32'sd1686629713;
  localparam logic signed [31:0] PI_QTR_Q30  = 32'sd843314857;
  localparam logic signed [31:0] PI_HALF_Q28 = 32'sd421657428;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] COEF_0      = 32'sd86476423;
  localparam logic signed [31:0] COEF_1      = 32'sd149010515;
  localparam logic signed [31:0] COEF_2      = 32'sd214509035;
  localparam logic signed [31:0] COEF_3      = 32'sd357909816;

  // Q1.30 product, rounded toward zero.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [31:0] r;
    ma = a[31] ? (~a + 32'd1) : a;
    mb = b[31] ? (~b + 32'd1) : b;
    p  = {32'b0, ma} * {32'b0, mb};
    r  = p[61:30];
    return (a[31] != b[31]) ? $signed(~r + 32'd1) : $signed(r);
  endfunction

endpackage

/* rtl/atu_root.sv */
// Acos argument clamp and pipelined integer square root of 1 - x^2.
module atu_root (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  atu_pkg::cmd_t       in_cmd,
  input  logic signed [31:0]  in_a,
  input  logic signed [31:0]  in_b,
  output logic                out_valid,
  output atu_pkg::cmd_t       out_cmd,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_x
);
  import atu_pkg::*;

  logic               vld_r  [0:SQRT_STEPS];
  cmd_t               cmd_r  [0:SQRT_STEPS];
  logic signed [31:0] a_r    [0:SQRT_STEPS];
  logic signed [31:0] b_r    [0:SQRT_STEPS];
  logic [32:0]        rem_r  [0:SQRT_STEPS];
  logic [16:0]        root_r [0:SQRT_STEPS];

  logic signed [31:0] v_clamp;
  logic [16:0]        mm;
  logic [33:0]        sq;
  logic [32:0]        d_nxt;

  always_comb begin
    if (in_a < -$signed(ONE_Q16)) v_clamp = -$signed(ONE_Q16);
    else if (in_a > $signed(ONE_Q16)) v_clamp = $signed(ONE_Q16);
    else v_clamp = in_a;
    mm    = v_clamp[31] ? 17'(-v_clamp) : v_clamp[16:0];
    sq    = {17'b0, mm} * {17'b0, mm};
    d_nxt = 33'h1_0000_0000 - sq[32:0];
  end

  // Acos carries its clamped argument in place of operand b.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0]  <= in_cmd;
      a_r[0]    <= in_a;
      b_r[0]    <= (in_cmd == CMD_ACOS) ? v_clamp : in_b;
      rem_r[0]  <= d_nxt;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
    localparam int BitIdx = SQRT_STEPS - k;
    logic [34:0] term;
    logic [34:0] rem_ext;
    logic        take;

    assign term    = ({18'b0, root_r[k-1]} << (BitIdx + 1)) + (35'd1 << (2 * BitIdx));
    assign rem_ext = {2'b0, rem_r[k-1]};
    assign take    = rem_ext >= term;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cmd_r[k]  <= cmd_r[k-1];
        a_r[k]    <= a_r[k-1];
        b_r[k]    <= b_r[k-1];
        rem_r[k]  <= take ? 33'(rem_ext - term) : rem_r[k-1];
        root_r[k] <= take ? (root_r[k-1] | (17'd1 << BitIdx)) : root_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_cmd   = cmd_r[SQRT_STEPS];
  assign out_y     = (cmd_r[SQRT_STEPS] == CMD_ACOS) ? $signed({15'b0, root_r[SQRT_STEPS]})
                                                     : a_r[SQRT_STEPS];
  assign out_x     = b_r[SQRT_STEPS];

endmodule

/* rtl/atu_quot.sv */
// Pipelined y/x quotient in Q16.16 with saturation, one bit a stage; plain atan passes |y| through.
module atu_quot (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  atu_pkg::cmd_t       in_cmd,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_x,
  output logic                out_valid,
  output atu_pkg::tag_t       out_tag,
  output logic                out_neg,
  output logic [31:0]         out_m
);
  import atu_pkg::*;

  logic        vld_r [0:QUOT_STEPS];
  tag_t        tag_r [0:QUOT_STEPS];
  logic        ovf_r [0:QUOT_STEPS];
  logic [31:0] my_r  [0:QUOT_STEPS];
  logic [31:0] mx_r  [0:QUOT_STEPS];
  logic [47:0] rem_r [0:QUOT_STEPS];
  logic [30:0] q_r   [0:QUOT_STEPS];

  logic [31:0] my;
  logic [31:0] mx;
  logic        ovf;
  tag_t        tag_nxt;

  always_comb begin
    my  = in_y[31] ? (~in_y + 32'd1) : in_y;
    mx  = in_x[31] ? (~in_x + 32'd1) : in_x;
    ovf = {16'b0, my} >= ({16'b0, mx} << 15);
    tag_nxt.cmd   = in_cmd;
    tag_nxt.xzero = (in_x == 32'sd0);
    tag_nxt.xneg  = in_x[31];
    tag_nxt.yneg  = in_y[31];
    tag_nxt.ypos  = !in_y[31] && (in_y != 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag_nxt;
      ovf_r[0] <= ovf;
      my_r[0]  <= my;
      mx_r[0]  <= mx;
      rem_r[0] <= {my, 16'b0};
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QUOT_STEPS; k++) begin : g_step
    localparam int BitIdx = QUOT_STEPS - k;
    logic [62:0] den_sh;
    logic        take;

    assign den_sh = {31'b0, mx_r[k-1]} << BitIdx;
    assign take   = {15'b0, rem_r[k-1]} >= den_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        my_r[k]  <= my_r[k-1];
        mx_r[k]  <= mx_r[k-1];
        rem_r[k] <= take ? (rem_r[k-1] - den_sh[47:0]) : rem_r[k-1];
        q_r[k]   <= take ? (q_r[k-1] | (31'd1 << BitIdx)) : q_r[k-1];
      end
    end
  end

  // Plain atan takes the magnitude of its argument straight through.
  always_comb begin
    out_valid = vld_r[QUOT_STEPS];
    out_tag   = tag_r[QUOT_STEPS];
    if (tag_r[QUOT_STEPS].cmd == CMD_ATAN) begin
      out_neg = tag_r[QUOT_STEPS].yneg;
      out_m   = my_r[QUOT_STEPS];
    end else begin
      out_neg = tag_r[QUOT_STEPS].yneg ^ tag_r[QUOT_STEPS].xneg;
      out_m   = ovf_r[QUOT_STEPS] ? 32'h7FFF_FFFF : {1'b0, q_r[QUOT_STEPS]};
    end
  end

endmodule

/* rtl/atu_reduce.sv */
// Range reduction at tan(pi/8) and tan(3pi/8) through a pipelined divider.
module atu_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  atu_pkg::tag_t       in_tag,
  input  logic                in_neg,
  input  logic [31:0]         in_m,
  output logic                out_valid,
  output atu_pkg::tag_t       out_tag,
  output logic                out_neg,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_off
);
  import atu_pkg::*;

  logic               vld_r  [0:RED_STEPS];
  tag_t               tag_r  [0:RED_STEPS];
  logic               neg_r  [0:RED_STEPS];
  logic               lo_r   [0:RED_STEPS];
  logic               xn_r   [0:RED_STEPS];
  logic signed [31:0] xlo_r  [0:RED_STEPS];
  logic signed [31:0] off_r  [0:RED_STEPS];
  logic [31:0]        den_r  [0:RED_STEPS];
  logic [46:0]        rem_r  [0:RED_STEPS];
  logic [29:0]        q_r    [0:RED_STEPS];

  logic               hi;
  logic               mid;
  logic [31:0]        dm_w;
  logic [46:0]        num;
  logic [31:0]        den;
  logic signed [31:0] off;

  always_comb begin
    hi   = in_m > TAN_3PI_8;
    mid  = !hi && (in_m > TAN_PI_8);
    dm_w = (in_m >= ONE_Q16) ? (in_m - ONE_Q16) : (ONE_Q16 - in_m);
    num  = hi ? (47'd1 << 46) : {dm_w[16:0], 30'b0};
    den  = hi ? in_m : (in_m + ONE_Q16);
    if (hi) off = PI_HALF_Q30;
    else if (mid) off = PI_QTR_Q30;
    else off = 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      neg_r[0] <= in_neg;
      lo_r[0]  <= !hi && !mid;
      xn_r[0]  <= hi || (mid && (in_m < ONE_Q16));
      xlo_r[0] <= $signed({3'b0, in_m[14:0], 14'b0});
      off_r[0] <= off;
      den_r[0] <= den;
      rem_r[0] <= num;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= RED_STEPS; k++) begin : g_step
    localparam int BitIdx = RED_STEPS - k;
    logic [61:0] den_sh;
    logic        take;

    assign den_sh = {30'b0, den_r[k-1]} << BitIdx;
    assign take   = {15'b0, rem_r[k-1]} >= den_sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_r[k-1];
        neg_r[k] <= neg_r[k-1];
        lo_r[k]  <= lo_r[k-1];
        xn_r[k]  <= xn_r[k-1];
        xlo_r[k] <= xlo_r[k-1];
        off_r[k] <= off_r[k-1];
        den_r[k] <= den_r[k-1];
        rem_r[k] <= take ? (rem_r[k-1] - den_sh[46:0]) : rem_r[k-1];
        q_r[k]   <= take ? (q_r[k-1] | (30'd1 << BitIdx)) : q_r[k-1];
      end
    end
  end

  always_comb begin
    out_valid = vld_r[RED_STEPS];
    out_tag   = tag_r[RED_STEPS];
    out_neg   = neg_r[RED_STEPS];
    out_off   = off_r[RED_STEPS];
    if (lo_r[RED_STEPS]) out_x = xlo_r[RED_STEPS];
    else if (xn_r[RED_STEPS]) out_x = -$signed({2'b0, q_r[RED_STEPS]});
    else out_x = $signed({2'b0, q_r[RED_STEPS]});
  end

endmodule

/* rtl/atu_poly.sv */
// Odd polynomial evaluation, rounding, sign and quadrant fix-up; holds the output word.
module atu_poly (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  atu_pkg::tag_t       in_tag,
  input  logic                in_neg,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_off,
  output logic                out_valid,
  output logic [30:0]         out_angle
);
  import atu_pkg::*;

  localparam int Depth = 6;

  typedef struct packed {
    tag_t               tag;
    logic               neg;
    logic signed [31:0] x;
    logic signed [31:0] off;
  } side_t;

  logic               vld_r [1:Depth+1];
  side_t              sd_r  [1:Depth];
  logic signed [31:0] x2_r  [1:Depth-2];
  logic signed [31:0] acc_r [2:Depth-1];
  logic signed [32:0] sum_r;
  logic [30:0]        angle_r;

  side_t              sd_in;
  logic signed [32:0] sum_nxt;
  logic [32:0]        sum_c;
  logic [32:0]        rnd;
  logic signed [31:0] res;
  logic signed [31:0] adj;
  logic signed [31:0] ang_nxt;

  assign sd_in = '{tag: in_tag, neg: in_neg, x: in_x, off: in_off};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= Depth + 1; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_valid;
      for (int k = 2; k <= Depth + 1; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign sum_nxt = 33'(mul_q30(acc_r[Depth-1], sd_r[Depth-1].x)) + 33'(sd_r[Depth-1].x)
                 + 33'(sd_r[Depth-1].off);

  // One multiply per stage up to sum_r: x^2, then Horner steps, then the final x factor.
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= sd_in;
      x2_r[1] <= mul_q30(in_x, in_x);
      for (int k = 2; k <= Depth; k++) sd_r[k] <= sd_r[k-1];
      for (int k = 2; k <= Depth - 2; k++) x2_r[k] <= x2_r[k-1];
      acc_r[2] <= mul_q30(COEF_0, x2_r[1]) - COEF_1;
      acc_r[3] <= mul_q30(acc_r[2], x2_r[2]) + COEF_2;
      acc_r[4] <= mul_q30(acc_r[3], x2_r[3]) - COEF_3;
      acc_r[5] <= mul_q30(acc_r[4], x2_r[4]);
      sum_r    <= sum_nxt;
      angle_r  <= ang_nxt[30:0];
    end
  end

  always_comb begin
    sum_c = sum_r[32] ? 33'd0 : sum_r;
    rnd   = (sum_c + 33'd2) >> 2;
    res   = sd_r[Depth].neg ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
    adj   = sd_r[Depth].tag.xneg ? (sd_r[Depth].tag.yneg ? -PI_Q28 : PI_Q28) : 32'sd0;
    case (sd_r[Depth].tag.cmd)
      CMD_ATAN: ang_nxt = res;
      CMD_ATAN2, CMD_ACOS: begin
        if (sd_r[Depth].tag.xzero) begin
          if (sd_r[Depth].tag.ypos) ang_nxt = PI_HALF_Q28;
          else if (sd_r[Depth].tag.yneg) ang_nxt = -PI_HALF_Q28;
          else ang_nxt = 32'sd0;
        end else begin
          ang_nxt = res + adj;
        end
      end
      default: ang_nxt = 32'sd0;
    endcase
  end

  assign out_valid = vld_r[Depth+1];
  assign out_angle = angle_r;

endmodule

/* rtl/arctangent_unit.sv */
// Arctangent unit top level: handshake, stall control and the four pipeline sections.
//
// Takes one word a cycle unless the output stalls, and returns one angle word per input word,
// in order, after 18 stages of acos clamp and square root (one root bit a stage), 32 stages
// of y/x division (one quotient bit a stage), 31 stages of range-reduction division, and 7
// stages of polynomial and fix-up ending in the output register. All commands take the same
// path and latency. The whole pipeline advances together; it holds while a result waits and
// out_ready is low, and in_ready follows that hold.
module arctangent_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_command,
  input  logic [31:0]  in_operand_a,
  input  logic [31:0]  in_operand_b,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [30:0]  out_angle
);
  import atu_pkg::*;

  logic               en;
  logic               r_valid;
  cmd_t               r_cmd;
  logic signed [31:0] r_y;
  logic signed [31:0] r_x;
  logic               q_valid;
  tag_t               q_tag;
  logic               q_neg;
  logic [31:0]        q_m;
  logic               d_valid;
  tag_t               d_tag;
  logic               d_neg;
  logic signed [31:0] d_x;
  logic signed [31:0] d_off;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  atu_root u_root (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .in_cmd   (cmd_t'(in_command)),
    .in_a     ($signed(in_operand_a)),
    .in_b     ($signed(in_operand_b)),
    .out_valid(r_valid),
    .out_cmd  (r_cmd),
    .out_y    (r_y),
    .out_x    (r_x)
  );

  atu_quot u_quot (
    .clk, .rst_n, .en,
    .in_valid (r_valid),
    .in_cmd   (r_cmd),
    .in_y     (r_y),
    .in_x     (r_x),
    .out_valid(q_valid),
    .out_tag  (q_tag),
    .out_neg  (q_neg),
    .out_m    (q_m)
  );

  atu_reduce u_reduce (
    .clk, .rst_n, .en,
    .in_valid (q_valid),
    .in_tag   (q_tag),
    .in_neg   (q_neg),
    .in_m     (q_m),
    .out_valid(d_valid),
    .out_tag  (d_tag),
    .out_neg  (d_neg),
    .out_x    (d_x),
    .out_off  (d_off)
  );

  atu_poly u_poly (
    .clk, .rst_n, .en,
    .in_valid (d_valid),
    .in_tag   (d_tag),
    .in_neg   (d_neg),
    .in_x     (d_x),
    .in_off   (d_off),
    .out_valid(out_valid),
    .out_angle(out_angle)
  );

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_angle) <= 31'(PI_Q28)) && ($signed(out_angle) >= -31'(PI_Q28)))
    else $error("angle outside +-pi");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the pipeline is held");

endmodule

/* verif/arctangent_unit_tb.sv */
// Self-checking testbench for the arctangent unit: directed and random atan, atan2, acos words.
`timescale 1ns / 100ps

module arctangent_unit_tb;
  import atu_pkg::*;

  localparam int LATENCY = 88;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_operand_a;
  logic [31:0] in_operand_b;
  logic        out_valid;
  logic        out_ready;
  logic [30:0] out_angle;

  logic [30:0] expected_angles[$];
  int          mismatches;
  int          angles_checked;
  int          words_sent;
  bit          steady;        // suppress idling on both sides
  int          stall_left;

  arctangent_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_angle   (out_angle)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Q1.30 product, truncated toward zero.
  function automatic longint q30_mul(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    r  = (ma * mb) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint atan_of(longint v);
    longint unsigned m;
    longint x;
    longint off;
    longint x2;
    longint s;
    longint sum;
    longint res;
    m = (v < 0) ? -v : v;
    if (m > longint'(TAN_3PI_8)) begin
      off = PI_HALF_Q30;
      x   = -longint'((64'd1 << 46) / m);
    end else if (m > longint'(TAN_PI_8)) begin
      off = PI_QTR_Q30;
      x   = ((longint'(m) - 65536) * (64'sd1 <<< 30)) / (longint'(m) + 65536);
    end else begin
      off = 0;
      x   = longint'(m) * 16384;
    end
    x2  = q30_mul(x, x);
    s   = COEF_0;
    s   = q30_mul(s, x2) - COEF_1;
    s   = q30_mul(s, x2) + COEF_2;
    s   = q30_mul(s, x2) - COEF_3;
    sum = q30_mul(q30_mul(s, x2), x) + x + off;
    if (sum < 0) sum = 0;
    res = (sum + 2) >>> 2;
    return (v < 0) ? -res : res;
  endfunction

  function automatic longint atan2_of(longint y, longint x);
    longint unsigned q;
    longint unsigned my;
    longint unsigned mx;
    longint a;
    if (x == 0) begin
      if (y > 0) return PI_HALF_Q28;
      if (y < 0) return -longint'(PI_HALF_Q28);
      return 0;
    end
    my = (y < 0) ? -y : y;
    mx = (x < 0) ? -x : x;
    q  = (my << 16) / mx;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    a = atan_of(((y < 0) != (x < 0)) ? -longint'(q) : longint'(q));
    if (x < 0) a += (y >= 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
    return a;
  endfunction

  // The argument never exceeds 2^32, so the root fits in 17 bits.
  function automatic longint root_floor(longint unsigned d);
    longint unsigned r;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= d) r |= 64'd1 << b;
    end
    return longint'(r);
  endfunction

  function automatic longint acos_of(longint v);
    longint unsigned mm;
    if (v < -65536) v = -65536;
    if (v > 65536) v = 65536;
    mm = (v < 0) ? -v : v;
    return atan2_of(root_floor((64'd1 << 32) - mm * mm), v);
  endfunction

  function automatic logic [30:0] predict_angle(cmd_t c, logic [31:0] a, logic [31:0] b);
    longint ya;
    longint xb;
    longint r;
    ya = longint'($signed(a));
    xb = longint'($signed(b));
    case (c)
      CMD_ATAN:  r = atan_of(ya);
      CMD_ATAN2: r = atan2_of(ya, xb);
      CMD_ACOS:  r = acos_of(ya);
      default:   r = 0;
    endcase
    return r[30:0];
  endfunction

  task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
    $display("mismatch %s: angle got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Send one word; entered and left just after a rising edge.
  task automatic send_word(cmd_t c, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= c;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    expected_angles.push_back(predict_angle(c, a, b));
    words_sent++;
  endtask

  // Checker: compare each accepted angle with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected word", out_angle, '0);
      end else begin
        logic [30:0] want;
        want = expected_angles.pop_front();
        angles_checked++;
        if (out_angle !== want) report_mismatch("value", out_angle, want);
      end
    end
  end

  // Output back-pressure: unless steady, may hold ready low for a random count after each word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (out_valid && out_ready && !steady) begin
      int n;
      n = $urandom_range(0, 12);
      if (n > 0) begin
        out_ready  <= 1'b0;
        stall_left <= n;
      end
    end
  end

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 200000);
      2:       return -$urandom_range(0, 200000);
      3:       return $urandom_range(20000, 170000) * (($urandom_range(0, 1)) ? 1 : -1);
      4:       return $urandom_range(0, 70000) * (($urandom_range(0, 1)) ? 1 : -1);
      default: return ($urandom_range(0, 1)) ? 32'd0 : $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_directed();
    send_word(CMD_ATAN, 32'd0, 32'd0);
    send_word(CMD_ATAN, 32'd65536, 32'hFFFF_FFFF);
    send_word(CMD_ATAN, -32'd65536, 32'd0);
    send_word(CMD_ATAN, 32'h7FFF_FFFF, 32'd0);
    send_word(CMD_ATAN, 32'h8000_0000, 32'd0);
    send_word(CMD_ATAN, 32'd158218, 32'd0);
    send_word(CMD_ATAN, 32'd158219, 32'd0);
    send_word(CMD_ATAN, 32'd27146, 32'd0);
    send_word(CMD_ATAN, -32'd27147, 32'd0);
    send_word(CMD_ATAN2, 32'd5, 32'd0);
    send_word(CMD_ATAN2, -32'd5, 32'd0);
    send_word(CMD_ATAN2, 32'd0, 32'd0);
    send_word(CMD_ATAN2, 32'd0, -32'd65536);
    send_word(CMD_ATAN2, -32'd65536, -32'd65536);
    send_word(CMD_ATAN2, 32'h7FFF_FFFF, 32'd1);
    send_word(CMD_ATAN2, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_ATAN2, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_ACOS, 32'd65536, 32'd0);
    send_word(CMD_ACOS, -32'd65536, 32'd0);
    send_word(CMD_ACOS, 32'd0, 32'd0);
    send_word(CMD_ACOS, 32'h7FFF_FFFF, 32'd0);
    send_word(CMD_ACOS, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(cmd_t c, int count);
    repeat (count) send_word(c, random_operand(), random_operand());
  endtask

  task automatic test_mixed(int count);
    repeat (count) begin
      if ($urandom_range(0, 63) == 0) steady = ~steady;
      send_word(cmd_t'($urandom_range(0, 2)), random_operand(), random_operand());
    end
    steady = 1'b0;
  endtask

  task automatic test_back_to_back(int count);
    steady = 1'b1;
    test_random(CMD_ATAN2, count);
    steady = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_ATAN;
    in_operand_a = '0;
    in_operand_b = '0;
    steady       = 1'b0;
    mismatches   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(CMD_ATAN, 300);
    test_random(CMD_ATAN2, 300);
    test_random(CMD_ACOS, 250);
    test_back_to_back(150);
    test_mixed(350);
    in_valid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d words over atan, atan2, acos and the unused command; %0d angles checked",
             words_sent, angles_checked);
    $display("random idling on both sides with stretches of back-to-back traffic");
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("arctangent_unit_tb: PASS");
    end else begin
      $display("arctangent_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("timeout with %0d angles outstanding", expected_angles.size());
    $display("arctangent_unit_tb: FAIL");
    $finish;
  end

endmodule
